### rtl/xcfd_pkg.sv
package xcfd_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned OFFSET_W = 17;
    localparam int unsigned IN_TDATA_W = 8;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned OUT_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGIN_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGOUT_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USERDEF_CODE = 3'd4;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_LENGTH = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_LOGIN_SHORT = 3'd4;
    localparam logic [2:0] ST_LOGOUT_SHORT = 3'd5;
    localparam logic [2:0] ST_MISMATCH = 3'd6;

    localparam logic [7:0] START_WORD [4] = '{8'h76, 8'h69, 8'h65, 8'h77};

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          out_byte;
        logic [OFFSET_W-1:0] byte_offset;
        logic [2:0]          status;
        logic [7:0]          command;
        logic [7:0]          sw_version;
        logic [7:0]          protocol_id;
        logic [15:0]         payload_length;
        logic                frame_last;
    } t_result;

endpackage

### rtl/xcfd_front.sv
module xcfd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [xcfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [xcfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    input  logic                           i_space,
    output logic                           o_ready,
    output logic                           o_push,
    output xcfd_pkg::t_result              o_result
);
    import xcfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHECK,
        PH_DROP
    } t_phase;

    localparam logic [OFFSET_W-1:0] OFF_CMD = 17'd4;
    localparam logic [OFFSET_W-1:0] OFF_VER = 17'd40;
    localparam logic [OFFSET_W-1:0] OFF_PROT = 17'd41;
    localparam logic [OFFSET_W-1:0] OFF_LEN_HI = 17'd42;
    localparam logic [OFFSET_W-1:0] OFF_LEN_LO = 17'd43;

    logic [15:0] r_max_len;
    logic [7:0]  r_login;
    logic [7:0]  r_logout;
    logic [7:0]  r_query;
    logic [7:0]  r_userdef;

    t_phase              r_phase, n_phase;
    logic [OFFSET_W-1:0] r_off, n_off;
    logic [7:0]          r_xor, n_xor;
    logic [7:0]          r_cmd, n_cmd;
    logic [7:0]          r_ver, n_ver;
    logic [7:0]          r_prot, n_prot;
    logic [15:0]         r_len, n_len;

    logic                accept;
    logic                emit;
    logic                close;
    logic [1:0]          res_kind;
    logic [2:0]          res_status;
    logic [7:0]          h_cmd, h_ver, h_prot;
    logic [15:0]         h_len;
    logic [7:0]          hdr_xor;

    function automatic logic [2:0] command_status(
        input logic [7:0]  cmd,
        input logic [15:0] len,
        input logic [7:0]  login,
        input logic [7:0]  logout,
        input logic [7:0]  query,
        input logic [7:0]  userdef
    );
        logic [2:0] st;
        if (cmd == login) begin
            st = (len < 16'd8) ? ST_LOGIN_SHORT : ((len > 16'd8) ? ST_MISMATCH : ST_OK);
        end else if (cmd == logout) begin
            st = (len < 16'd8) ? ST_LOGOUT_SHORT : ((len > 16'd8) ? ST_MISMATCH : ST_OK);
        end else if (cmd == query) begin
            st = (len != 16'd0) ? ST_MISMATCH : ST_OK;
        end else if (cmd == userdef) begin
            st = ST_OK;
        end else begin
            st = (len != 16'd0) ? ST_MISMATCH : ST_OK;
        end
        return st;
    endfunction

    assign o_ready = i_space;
    assign accept = i_valid & i_space;

    always_comb begin
        h_cmd = (r_off == OFF_CMD) ? i_byte : r_cmd;
        h_ver = (r_off == OFF_VER) ? i_byte : r_ver;
        h_prot = (r_off == OFF_PROT) ? i_byte : r_prot;
        if (r_off == OFF_LEN_HI) begin
            h_len = {i_byte, 8'h00};
        end else if (r_off == OFF_LEN_LO) begin
            h_len = {r_len[15:8], i_byte};
        end else begin
            h_len = r_len;
        end
        hdr_xor = (r_off >= 17'd2) ? (r_xor ^ i_byte) : r_xor;
    end

    always_comb begin
        n_phase = r_phase;
        n_off = r_off;
        n_xor = r_xor;
        n_cmd = r_cmd;
        n_ver = r_ver;
        n_prot = r_prot;
        n_len = r_len;
        emit = 1'b0;
        close = 1'b0;
        res_kind = KIND_HEADER;
        res_status = ST_OK;

        unique case (r_phase)
            PH_DROP: begin
            end
            PH_HEADER: begin
                emit = 1'b1;
                n_cmd = h_cmd;
                n_ver = h_ver;
                n_prot = h_prot;
                n_len = h_len;
                n_xor = hdr_xor;
                if (r_off < 17'd4 && i_byte != START_WORD[r_off[1:0]]) begin
                    res_kind = KIND_END;
                    res_status = ST_BAD_START;
                    close = 1'b1;
                end else if (r_off == OFF_LEN_LO && h_len > r_max_len) begin
                    res_kind = KIND_END;
                    res_status = ST_LENGTH;
                    close = 1'b1;
                end else if (i_last) begin
                    res_kind = KIND_END;
                    res_status = ST_LENGTH;
                    close = 1'b1;
                end else begin
                    n_off = r_off + 17'd1;
                    if (r_off == OFF_LEN_LO) begin
                        n_phase = (h_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                emit = 1'b1;
                n_xor = r_xor ^ i_byte;
                if (i_last) begin
                    res_kind = KIND_END;
                    res_status = ST_LENGTH;
                    close = 1'b1;
                end else begin
                    res_kind = KIND_PAYLOAD;
                    n_off = r_off + 17'd1;
                    if ({1'b0, r_off} >= 18'(OFF_LEN_LO) + 18'(r_len)) begin
                        n_phase = PH_CHECK;
                    end
                end
            end
            PH_CHECK: begin
                emit = 1'b1;
                close = 1'b1;
                res_kind = KIND_END;
                res_status = (r_xor != i_byte) ? ST_CHECKSUM :
                    command_status(r_cmd, r_len, r_login, r_logout, r_query, r_userdef);
            end
            default: begin
            end
        endcase

        if (close) begin
            n_phase = PH_DROP;
        end
        if ((close || r_phase == PH_DROP) && i_last) begin
            n_phase = PH_HEADER;
            n_off = '0;
            n_xor = '0;
            n_cmd = '0;
            n_ver = '0;
            n_prot = '0;
            n_len = '0;
        end
    end

    assign o_push = accept & emit;

    always_comb begin
        o_result.kind = res_kind;
        o_result.out_byte = i_byte;
        o_result.byte_offset = r_off;
        o_result.status = res_status;
        o_result.command = (r_phase == PH_HEADER) ? h_cmd : r_cmd;
        o_result.sw_version = (r_phase == PH_HEADER) ? h_ver : r_ver;
        o_result.protocol_id = (r_phase == PH_HEADER) ? h_prot : r_prot;
        o_result.payload_length = (r_phase == PH_HEADER) ? h_len : r_len;
        o_result.frame_last = (res_kind == KIND_END);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'hFFFF;
            r_login <= 8'd1;
            r_logout <= 8'd2;
            r_query <= 8'd3;
            r_userdef <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_PAYLOAD_LEN: r_max_len <= i_cfg_data;
                CFG_LOGIN_CODE:      r_login <= i_cfg_data[7:0];
                CFG_LOGOUT_CODE:     r_logout <= i_cfg_data[7:0];
                CFG_QUERY_CODE:      r_query <= i_cfg_data[7:0];
                CFG_USERDEF_CODE:    r_userdef <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_off <= '0;
            r_xor <= '0;
            r_cmd <= '0;
            r_ver <= '0;
            r_prot <= '0;
            r_len <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_off <= n_off;
            r_xor <= n_xor;
            r_cmd <= n_cmd;
            r_ver <= n_ver;
            r_prot <= n_prot;
            r_len <= n_len;
        end
    end

endmodule

### rtl/xcfd_back.sv
module xcfd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  xcfd_pkg::t_result                   i_result,
    output logic                                o_space,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [xcfd_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic [xcfd_pkg::OUT_TUSER_W-1:0]    o_tuser,
    output logic                                o_tlast
);
    import xcfd_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_result           r_queue [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W:0]    r_count;
    logic              pop;
    t_result           head;

    assign o_space = (r_count != (PTR_W + 1)'(DEPTH));
    assign o_tvalid = (r_count != '0);
    assign pop = o_tvalid & i_tready;
    assign head = r_queue[r_rd_ptr];

    assign o_tdata = {4'h0, head.payload_length, head.protocol_id, head.sw_version,
                      head.command, head.status, head.byte_offset, head.out_byte};
    assign o_tuser = head.kind;
    assign o_tlast = head.frame_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_queue[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/xor_checked_frame_deframer_core.sv
// Byte-serial deframer for one packet per received buffer: checks the start word, captures
// the header, forwards the payload and verifies the trailing XOR check byte, closing each
// frame with a status transaction. One input byte is accepted every clock cycle while the
// four-entry result queue has space; each result is written to that queue as its byte is
// accepted. The input stalls only once four results wait unread on the output side.
module xor_checked_frame_deframer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [xcfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [xcfd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] byte_value
    input  logic [xcfd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] out_byte, [24:8] byte_offset, [27:25] status, [35:28] command,
    // [43:36] sw_version, [51:44] protocol_id, [67:52] payload_length, [71:68] zero
    output logic [xcfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] kind
    output logic [xcfd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast
);
    import xcfd_pkg::*;

    logic    space;
    logic    push;
    t_result result;

    xcfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata[7:0]),
        .i_last      (s_axis_tlast),
        .i_space     (space),
        .o_ready     (s_axis_tready),
        .o_push      (push),
        .o_result    (result)
    );

    xcfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_space  (space),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
